### rtl/sum8_checked_frame_parser_top_assert.svh
// Assertion macros for the sum8 checked frame parser.
// Used by the port checker; depends on clk and rst_n being in scope.
`ifndef SUM8_CHECKED_FRAME_PARSER_TOP_ASSERT_SVH
`define SUM8_CHECKED_FRAME_PARSER_TOP_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define S8FP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define S8FP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/s8fp_pkg.sv
// Shared types and constants of the sum8 checked frame parser.
// Used by the front, the descriptor queue, the back end and the top level.
package s8fp_pkg;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_MSG_ID = 2'd1;
  localparam logic [7:0] HEADER_RESET = 8'hEF;

  // Parser phase: what the next received byte means.
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_DEV,
    PH_SYS,
    PH_MSG,
    PH_SEQ,
    PH_LEN,
    PH_PAY,
    PH_SUM
  } phase_t;

  // One checked frame handed from the front to the back end.
  typedef struct packed {
    logic [7:0] dev_id;
    logic [7:0] sys_id;
    logic [7:0] msg_id;
    logic [7:0] seq_num;
    logic [6:0] payload_len;
    logic       id_match;
    logic       bank;
  } desc_t;

  // One result item.
  typedef struct packed {
    logic [7:0] dev_id;
    logic [7:0] sys_id;
    logic [7:0] msg_id;
    logic [7:0] seq_num;
    logic [6:0] payload_len;
    logic [5:0] byte_index;
    logic [7:0] payload_byte;
    logic       byte_present;
    logic       id_match;
    logic       last;
  } result_t;

  // Buffer bank handed back by the back end once fully read.
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

### rtl/s8fp_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module s8fp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/s8fp_desc_q.sv
// Two-entry queue of checked frame descriptors between front and back end.
// Depends on s8fp_pkg for desc_t.
module s8fp_desc_q
  import s8fp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output desc_t head_data
);

  desc_t      entry_r [2];
  logic       head_r, head_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       tail;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = entry_r[head_r];
  assign tail       = head_r ^ cnt_r[0];

  // Occupancy and head pointer.
  always_comb begin
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
    head_nxt = head_r ^ pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      head_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[tail] <= push_data;
    end
  end

endmodule

### rtl/s8fp_front.sv
// Front end: hunts for frames, stores payload bytes, checks the sum.
// Depends on s8fp_pkg; writes the payload RAM and pushes into the descriptor queue.
module s8fp_front
  import s8fp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64,
  parameter int IDX_W       = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_rx_byte,
  input  logic [7:0]       header_byte,
  input  logic [7:0]       wanted_msg_id,
  output logic             ram_we,
  output logic [IDX_W:0]   ram_waddr,
  output logic [7:0]       ram_wdata,
  output logic             q_push,
  output desc_t            q_data,
  input  logic             q_full,
  input  release_t         rel
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] dev_r, dev_nxt;
  logic [7:0] sys_r, sys_nxt;
  logic [7:0] msg_r, msg_nxt;
  logic [7:0] seq_r, seq_nxt;
  logic [6:0] len_r, len_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       bank_r, bank_nxt;
  logic [1:0] busy_r, busy_nxt;
  logic       acc;
  logic [7:0] sum_add;
  logic       sum_ok;

  assign acc     = in_valid && in_ready;
  assign sum_add = sum_r + in_rx_byte;
  assign sum_ok  = (sum_r == in_rx_byte);

  // Next state of the parser.
  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    dev_nxt   = dev_r;
    sys_nxt   = sys_r;
    msg_nxt   = msg_r;
    seq_nxt   = seq_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    bank_nxt  = bank_r;
    if (acc) begin
      case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == header_byte) begin
            sum_nxt   = in_rx_byte;
            phase_nxt = PH_DEV;
          end
        end
        PH_DEV: begin
          dev_nxt   = in_rx_byte;
          sum_nxt   = sum_add;
          phase_nxt = PH_SYS;
        end
        PH_SYS: begin
          sys_nxt   = in_rx_byte;
          sum_nxt   = sum_add;
          phase_nxt = PH_MSG;
        end
        PH_MSG: begin
          msg_nxt   = in_rx_byte;
          sum_nxt   = sum_add;
          phase_nxt = PH_SEQ;
        end
        PH_SEQ: begin
          seq_nxt   = in_rx_byte;
          sum_nxt   = sum_add;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          sum_nxt = sum_add;
          // An oversized length drops the frame.
          if (in_rx_byte > 8'(MAX_PAYLOAD)) begin
            phase_nxt = PH_HUNT;
          end else begin
            len_nxt   = in_rx_byte[6:0];
            cnt_nxt   = '0;
            phase_nxt = (in_rx_byte == 8'd0) ? PH_SUM : PH_PAY;
          end
        end
        PH_PAY: begin
          sum_nxt = sum_add;
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_nxt >= len_r) begin
            phase_nxt = PH_SUM;
          end
        end
        PH_SUM: begin
          phase_nxt = PH_HUNT;
          // A checked frame with payload takes its bank; the next frame uses the other.
          if (sum_ok && (len_r != 7'd0)) begin
            bank_nxt = ~bank_r;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  // Handshake, payload write and descriptor push.
  always_comb begin
    case (phase_r)
      PH_PAY:  in_ready = !busy_r[bank_r];
      PH_SUM:  in_ready = !q_full;
      default: in_ready = 1'b1;
    endcase
    ram_we    = acc && (phase_r == PH_PAY);
    ram_waddr = {bank_r, cnt_r[IDX_W-1:0]};
    ram_wdata = in_rx_byte;
    q_push    = acc && (phase_r == PH_SUM) && sum_ok;
    q_data    = '{dev_id:      dev_r,
                  sys_id:      sys_r,
                  msg_id:      msg_r,
                  seq_num:     seq_r,
                  payload_len: len_r,
                  id_match:    (msg_r == wanted_msg_id),
                  bank:        bank_r};
  end

  // Bank ownership: set on push of a frame with payload, cleared when the back end has read it all.
  always_comb begin
    busy_nxt = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (q_push && (len_r != 7'd0)) begin
      busy_nxt[bank_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sum_r   <= '0;
      dev_r   <= '0;
      sys_r   <= '0;
      msg_r   <= '0;
      seq_r   <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      bank_r  <= 1'b0;
      busy_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      dev_r   <= dev_nxt;
      sys_r   <= sys_nxt;
      msg_r   <= msg_nxt;
      seq_r   <= seq_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      bank_r  <= bank_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

### rtl/s8fp_back.sv
// Back end: walks each checked frame, reads its payload and queues results.
// Depends on s8fp_pkg; reads the payload RAM and pops the descriptor queue.
module s8fp_back
  import s8fp_pkg::*;
#(
  parameter int IDX_W = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  desc_t          q_data,
  output logic           q_pop,
  output logic           ram_re,
  output logic [IDX_W:0] ram_raddr,
  input  logic [7:0]     ram_rdata,
  output release_t       rel,
  output logic           out_valid,
  input  logic           out_ready,
  output result_t        out_res
);

  logic       have_r, have_nxt;
  desc_t      cur_r;
  logic [6:0] idx_r, idx_nxt;
  logic       pend_r;
  result_t    pend_res_r, pend_res_nxt;
  result_t    fifo_r [2];
  logic       head_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop, issue, is_empty, last_issue, tail;
  result_t    land_res;

  assign pop        = out_valid && out_ready;
  assign out_valid  = (cnt_r != 2'd0);
  assign out_res    = fifo_r[head_r];
  assign is_empty   = (cur_r.payload_len == 7'd0);
  assign last_issue = is_empty || ((idx_r + 7'd1) == cur_r.payload_len);
  assign tail       = head_r ^ cnt_r[0];

  // Issue one result per cycle while the result FIFO has room for it on landing.
  assign issue = have_r &&
                 (({1'b0, cnt_r} + {2'b0, pend_r}) <= (3'd1 + {2'b0, pop}));
  assign q_pop = !have_r && q_valid;

  assign ram_re    = issue && !is_empty;
  assign ram_raddr = {cur_r.bank, idx_r[IDX_W-1:0]};
  assign rel       = '{valid: issue && last_issue && !is_empty, bank: cur_r.bank};

  // Frame walk and the metadata of the read in flight.
  always_comb begin
    have_nxt = have_r;
    idx_nxt  = idx_r;
    if (q_pop) begin
      have_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (issue) begin
      idx_nxt = idx_r + 7'd1;
      if (last_issue) begin
        have_nxt = 1'b0;
      end
    end
    pend_res_nxt = '{dev_id:       cur_r.dev_id,
                     sys_id:       cur_r.sys_id,
                     msg_id:       cur_r.msg_id,
                     seq_num:      cur_r.seq_num,
                     payload_len:  cur_r.payload_len,
                     byte_index:   idx_r[5:0],
                     payload_byte: 8'd0,
                     byte_present: !is_empty,
                     id_match:     cur_r.id_match,
                     last:         last_issue};
    // The landing result takes the RAM byte; the empty marker keeps zero.
    land_res = pend_res_r;
    if (pend_res_r.byte_present) begin
      land_res.payload_byte = ram_rdata;
    end
    cnt_nxt = cnt_r + {1'b0, pend_r} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      idx_r  <= '0;
      pend_r <= 1'b0;
      cnt_r  <= '0;
      head_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
      idx_r  <= idx_nxt;
      pend_r <= issue;
      cnt_r  <= cnt_nxt;
      head_r <= head_r ^ pop;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (issue) begin
      pend_res_r <= pend_res_nxt;
    end
    if (pend_r) begin
      fifo_r[tail] <= land_res;
    end
  end

endmodule

### rtl/sum8_checked_frame_parser_top.sv
// Top level of the sum8 checked frame parser: configuration registers and wiring.
// Depends on s8fp_pkg, s8fp_front, s8fp_desc_q, s8fp_back and s8fp_ram.
//
// The parser takes one received byte per cycle. It finds the header byte, collects
// device, system and message ids, sequence and length, stores the payload and checks
// the mod-256 sum of the frame against the checksum byte. A checked frame yields one
// result per payload byte (a single marker result for an empty payload) at up to one
// result per cycle, after the frame queue, the RAM read and the result FIFO. Payload
// goes into a RAM of two banks of MAX_PAYLOAD bytes, rounded up to a power of two,
// so one frame can be received while the previous one drains. The input stalls on a
// payload byte while both banks still hold undrained frames, and on a checksum byte
// while the two-entry frame queue is full; otherwise no byte stalls. Configuration must
// be written only while the parser is idle; the block does not enforce this.
module sum8_checked_frame_parser_top
  import s8fp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_dev_id,
  output logic [7:0]           out_sys_id,
  output logic [7:0]           out_msg_id,
  output logic [7:0]           out_seq_num,
  output logic [6:0]           out_payload_len,
  output logic [5:0]           out_byte_index,
  output logic [7:0]           out_payload_byte,
  output logic                 out_byte_present,
  output logic                 out_id_match,
  output logic                 out_last,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int IDX_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int RAM_DEPTH = 2 * (2 ** IDX_W);

  logic [7:0]     header_r, wanted_r;
  logic           ram_we, ram_re;
  logic [IDX_W:0] ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;
  logic           q_push, q_full, q_pop, q_valid;
  desc_t          q_in, q_head;
  release_t       rel;
  result_t        res;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RESET;
      wanted_r <= 8'd0;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_HEADER_BYTE) begin
        header_r <= cfg_data;
      end else if (cfg_index == REG_WANTED_MSG_ID) begin
        wanted_r <= cfg_data;
      end
    end
  end

  s8fp_front #(.MAX_PAYLOAD(MAX_PAYLOAD), .IDX_W(IDX_W)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .header_byte   (header_r),
    .wanted_msg_id (wanted_r),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .q_push        (q_push),
    .q_data        (q_in),
    .q_full        (q_full),
    .rel           (rel)
  );

  s8fp_desc_q u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  s8fp_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  s8fp_back #(.IDX_W(IDX_W)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .rel       (rel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  // Result fields.
  assign out_dev_id       = res.dev_id;
  assign out_sys_id       = res.sys_id;
  assign out_msg_id       = res.msg_id;
  assign out_seq_num      = res.seq_num;
  assign out_payload_len  = res.payload_len;
  assign out_byte_index   = res.byte_index;
  assign out_payload_byte = res.payload_byte;
  assign out_byte_present = res.byte_present;
  assign out_id_match     = res.id_match;
  assign out_last         = res.last;

endmodule

### rtl/s8fp_checker.sv
// Port-level checker for the sum8 checked frame parser, bound to the top level.
// Depends on the assertion macros in sum8_checked_frame_parser_top_assert.svh.
`include "sum8_checked_frame_parser_top_assert.svh"

module s8fp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_dev_id,
  input logic [7:0] out_sys_id,
  input logic [7:0] out_msg_id,
  input logic [7:0] out_seq_num,
  input logic [6:0] out_payload_len,
  input logic [5:0] out_byte_index,
  input logic [7:0] out_payload_byte,
  input logic       out_byte_present,
  input logic       out_id_match,
  input logic       out_last
);

  logic [6:0]  next_index;
  logic [55:0] out_all;

  assign next_index = {1'b0, out_byte_index} + 7'd1;

  // Every field of the result item, for the hold check.
  assign out_all = {out_dev_id, out_sys_id, out_msg_id, out_seq_num, out_payload_len,
                    out_byte_index, out_payload_byte, out_byte_present, out_id_match,
                    out_last};

  // A stalled result keeps its contents.
  `S8FP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_all), "result changed while stalled")

  // The empty payload marker is the only, and last, result of its frame.
  `S8FP_ASSERT_IMP(a_marker, out_valid && !out_byte_present, out_last && (out_payload_len == 7'd0) && (out_byte_index == 6'd0) && (out_payload_byte == 8'd0), "malformed empty payload marker")

  // A payload byte lies inside the frame's payload.
  `S8FP_ASSERT_IMP(a_index_range, out_valid && out_byte_present, next_index <= out_payload_len, "payload byte index beyond length")

  // The last flag marks exactly the final payload byte.
  `S8FP_ASSERT_IMP(a_last_flag, out_valid && out_byte_present, out_last == (next_index == out_payload_len), "last flag on wrong payload byte")

endmodule

bind sum8_checked_frame_parser_top s8fp_checker u_s8fp_checker (.*);
